@@ rtl/core/cnlc_pkg.sv @@
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and constants of the card number classifier
// Widths, step counts, class codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cnlc_pkg;

  localparam int CARD_W        = 63;
  localparam int BIN_W         = 64;              // card number padded to a nibble multiple
  localparam int NUM_DIGITS    = 19;
  localparam int DIGIT_W       = 4;
  localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
  localparam int CNT_W         = 5;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [1:0]         card_class_t;

  localparam card_class_t CLASS_INVALID = 2'd0;
  localparam card_class_t CLASS_15_3X   = 2'd1;   // 15 digits, 34 or 37
  localparam card_class_t CLASS_16_5X   = 2'd2;   // 16 digits, 51..55
  localparam card_class_t CLASS_LEAD_4  = 2'd3;   // 13 or 16 digits, leading 4

  localparam count_t LEN_13 = 5'd13;
  localparam count_t LEN_15 = 5'd15;
  localparam count_t LEN_16 = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;    // take a new card number
    logic conv;    // one binary-to-BCD step
    logic shift;   // present the next digit
  } bcd_ctrl_t;

  typedef struct packed {
    logic   clear;
    logic   step;
    count_t pos;
  } scan_ctrl_t;

  typedef struct packed {
    logic   ok;
    count_t count;
    digit_t lead_hi;
    digit_t lead_lo;
  } scan_res_t;

  function automatic card_class_t classify(input scan_res_t r);
    card_class_t c;
    c = CLASS_INVALID;
    if (r.ok) begin
      if (r.count == LEN_15) begin
        if (r.lead_hi == 4'd3 && (r.lead_lo == 4'd4 || r.lead_lo == 4'd7)) c = CLASS_15_3X;
      end else if (r.count == LEN_16) begin
        if (r.lead_hi == 4'd5 && r.lead_lo >= 4'd1 && r.lead_lo <= 4'd5) c = CLASS_16_5X;
        else if (r.lead_hi == 4'd4) c = CLASS_LEAD_4;
      end else if (r.count == LEN_13) begin
        if (r.lead_hi == 4'd4) c = CLASS_LEAD_4;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cnlc_bcd.sv @@
// ----------------------------------------------------------------------------
// cnlc_bcd: shift-and-add-3 binary to BCD converter
// Four bits per step; afterwards shifts out one BCD digit per step, LSD first.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_bcd (
  input  wire logic                      clk,
  input  wire cnlc_pkg::bcd_ctrl_t       ctrl,
  input  wire logic [cnlc_pkg::CARD_W-1:0] card_number,
  output logic [cnlc_pkg::DIGIT_W-1:0]   digit
);
  import cnlc_pkg::*;

  logic [BCD_W+BIN_W-1:0] shreg;
  logic [BCD_W+BIN_W-1:0] conv_next;

  // four dependent adjust-and-shift passes over nineteen independent digits
  always_comb begin
    logic [BCD_W+BIN_W-1:0] t;
    t = shreg;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
        if (t[BIN_W + j*DIGIT_W +: DIGIT_W] >= 4'd5)
          t[BIN_W + j*DIGIT_W +: DIGIT_W] = t[BIN_W + j*DIGIT_W +: DIGIT_W] + 4'd3;
      end
      t = {t[BCD_W+BIN_W-2:0], 1'b0};
    end
    conv_next = t;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg <= {{(BCD_W+BIN_W-CARD_W){1'b0}}, card_number};
    end else if (ctrl.conv) begin
      shreg <= conv_next;
    end else if (ctrl.shift) begin
      shreg <= {{DIGIT_W{1'b0}}, shreg[BCD_W+BIN_W-1:DIGIT_W]};
    end
  end

  assign digit = shreg[BIN_W +: DIGIT_W];

endmodule

`default_nettype wire

@@ rtl/core/cnlc_scan.sv @@
// ----------------------------------------------------------------------------
// cnlc_scan: Luhn digit accumulator
// Sums digits mod 10, doubling odd positions; tracks length and lead digits.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_scan (
  input  wire logic                        clk,
  input  wire cnlc_pkg::scan_ctrl_t        ctrl,
  input  wire logic [cnlc_pkg::DIGIT_W-1:0] digit,
  output cnlc_pkg::scan_res_t              res
);
  import cnlc_pkg::*;

  digit_t acc, acc_next;
  count_t count;
  digit_t lead_hi, lead_lo, prev;
  logic [4:0] dbl, term, total;

  always_comb begin
    dbl  = {digit, 1'b0};
    term = {1'b0, digit};
    if (ctrl.pos[0]) begin
      term = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
    end
    total    = {1'b0, acc} + term;
    acc_next = (total >= 5'd10) ? 4'(total - 5'd10) : total[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc     <= '0;
      count   <= 5'd1;
      lead_hi <= '0;
      lead_lo <= '0;
      prev    <= '0;
    end else if (ctrl.step) begin
      acc  <= acc_next;
      prev <= digit;
      if (digit != '0) begin
        count   <= ctrl.pos + 5'd1;
        lead_hi <= digit;
        lead_lo <= prev;
      end
    end
  end

  always_comb begin
    res.ok      = (acc == '0);
    res.count   = count;
    res.lead_hi = lead_hi;
    res.lead_lo = lead_lo;
  end

endmodule

`default_nettype wire

@@ rtl/core/card_number_luhn_classifier_top.sv @@
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_top: Luhn check and class code of a card number
// Sequencer around a BCD converter and a digit accumulator, output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: card_number with in_valid / in_stall. A request is taken
//   when in_valid is high and in_stall is low; in_stall is high while a
//   number is being worked on.
//   Output channel: card_class, checksum_ok, digit_count with out_valid /
//   out_stall. One result per request, held stable while out_stall is high.
//   Sequence: conversion at 4 bits per cycle through the shift-add-3
//   converter, then the scan at one digit per cycle into the accumulator,
//   then the classify state, which loads the output register; a new
//   request is taken only once the sequencer is back in idle.
//   The output register frees the sequencer: a new request is taken while a
//   finished result still waits; the next result waits in the classify
//   state until the output register is free.
//   Reset (rst, synchronous, active high) returns the sequencer to idle and
//   drops out_valid; data registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cnlc_pkg::CARD_W-1:0] card_number,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       card_class,
  output logic                             checksum_ok,
  output logic [cnlc_pkg::CNT_W-1:0]       digit_count
);
  import cnlc_pkg::*;

  state_t     state, state_next;
  count_t     step, step_next;
  bcd_ctrl_t  bcd_ctrl;
  scan_ctrl_t scan_ctrl;
  scan_res_t  scan_res;
  digit_t     digit;
  logic       out_free;
  logic       out_load;

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (step == 5'(CONV_STEPS - 1)) begin
          step_next  = '0;
          state_next = ST_SCAN;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_SCAN: begin
        if (step == 5'(NUM_DIGITS - 1)) begin
          step_next  = '0;
          state_next = ST_DONE;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall        = 1'b1;
    bcd_ctrl        = '0;
    scan_ctrl       = '0;
    scan_ctrl.pos   = step;
    out_load        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall        = 1'b0;
        bcd_ctrl.load   = in_valid;
        scan_ctrl.clear = in_valid;
      end
      ST_CONV: bcd_ctrl.conv = 1'b1;
      ST_SCAN: begin
        bcd_ctrl.shift = 1'b1;
        scan_ctrl.step = 1'b1;
      end
      ST_DONE: out_load = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      card_class  <= classify(scan_res);
      checksum_ok <= scan_res.ok;
      digit_count <= scan_res.count;
    end
  end

  cnlc_bcd u_bcd (
    .clk         (clk),
    .ctrl        (bcd_ctrl),
    .card_number (card_number),
    .digit       (digit)
  );

  cnlc_scan u_scan (
    .clk   (clk),
    .ctrl  (scan_ctrl),
    .digit (digit),
    .res   (scan_res)
  );

endmodule

`default_nettype wire
